FILE: design/u2p_pkg.sv
// Package: constants, types and tables for the USB boot-keyboard to PS/2 converter.
`timescale 1ns / 1ps
package u2p_pkg;

   localparam int MAP_DEPTH  = 112;
   localparam int KEY_SLOTS  = 6;
   localparam int SLOT_MAX   = 6;
   localparam int MOD_COUNT  = 8;
   localparam int EV_COUNT   = MOD_COUNT + 2 * KEY_SLOTS;
   localparam int EV_W       = $clog2(EV_COUNT + 1);
   localparam int SLOT_W     = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam int MAP_ADDR_W = $clog2(MAP_DEPTH);

   localparam logic [7:0] PFX_EXT    = 8'he0;
   localparam logic [7:0] PFX_BREAK  = 8'hf0;
   localparam logic [7:0] CODE_LIMIT = 8'h70;
   localparam int         EXT_BIT    = 8;

   localparam logic [8:0] MOD_CODES [MOD_COUNT] = '{
      9'h014, 9'h012, 9'h011, 9'h11f, 9'h114, 9'h059, 9'h111, 9'h127
   };

   localparam logic REG_ID_CHECK    = 1'b0;
   localparam logic REG_EXPECTED_ID = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_BYTE,
      ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      PH_EXT,
      PH_BREAK,
      PH_CODE
   } phase_type;

endpackage

FILE: design/u2p_if.sv
// Interfaces: report/map-write input channel and scan-byte output channel.
`timescale 1ns / 1ps
interface u2p_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] report_id_byte;
   logic [7:0] modifier_bits;
   logic [7:0] key_slot0;
   logic [7:0] key_slot1;
   logic [7:0] key_slot2;
   logic [7:0] key_slot3;
   logic [7:0] key_slot4;
   logic [7:0] key_slot5;
   logic [6:0] map_index;
   logic [8:0] map_entry;

   modport source (output valid, cmd, report_id_byte, modifier_bits, key_slot0, key_slot1,
                   key_slot2, key_slot3, key_slot4, key_slot5, map_index, map_entry,
                   input ready);
   modport sink (input valid, cmd, report_id_byte, modifier_bits, key_slot0, key_slot1,
                 key_slot2, key_slot3, key_slot4, key_slot5, map_index, map_entry,
                 output ready);
endinterface

interface u2p_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] scan_byte;
   logic       parity_bit;
   logic       last_of_run;

   modport source (output valid, scan_byte, parity_bit, last_of_run, input ready);
   modport sink (input valid, scan_byte, parity_bit, last_of_run, output ready);
endinterface

FILE: design/usb_boot_keyboard_to_ps2_scancodes.sv
// Top level: USB boot-keyboard report to PS/2 set-2 scan-code sequencer.
// A sequencer walks the 20 modifier/slot events in order, one per cycle for an inactive
// event; an active event sends its bytes one per cycle while the output is not stalled,
// with one key map read per active slot event. A report sends at most 60 bytes, and a
// new report is accepted only in the idle state, after the previous run has finished.
// Reset clears control, previous report and registers; key map is undefined until written.
`timescale 1ns / 1ps
module usb_boot_keyboard_to_ps2_scancodes (
   input  logic        clock,
   input  logic        reset,
   u2p_req_if.sink     req_ch,
   u2p_rsp_if.source   rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [8:0] key_map_mem [u2p_pkg::MAP_DEPTH];
   logic [8:0] rd_q_ff;

   u2p_pkg::state_type state_ff, state_in;
   u2p_pkg::phase_type ph_ff, ph_in, sel;
   logic [u2p_pkg::EV_W-1:0] ev_ff, ev_in;
   logic       brk_ff, brk_in;
   logic       use_mem_ff, use_mem_in;
   logic [8:0] entry_ff, entry_in;
   logic       id_chk_ff;
   logic [7:0] exp_id_ff;
   logic [7:0] cur_mods_ff, prev_mods_ff;
   logic [7:0] cur_keys_ff  [u2p_pkg::KEY_SLOTS];
   logic [7:0] prev_keys_ff [u2p_pkg::KEY_SLOTS];
   logic [7:0] in_keys [u2p_pkg::SLOT_MAX];
   logic       pend_valid_ff, pend_valid_in;
   logic [7:0] pend_byte_ff, pend_byte_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;

   logic       accept, start, map_wr, mem_rd, can_push, push;
   logic [7:0] idx8;
   logic [u2p_pkg::EV_W-1:0] ev_k;
   logic [u2p_pkg::SLOT_W-1:0] slot_raw, slot_sel;
   logic [7:0] was, now, code;
   logic       ev_is_mod, key_brk, key_active, mod_active;
   logic [2:0] mod_idx;
   logic [8:0] entry;
   logic [7:0] gen_byte;
   logic       wr_en;

   // configuration port
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign prdata = (paddr[2] == u2p_pkg::REG_EXPECTED_ID) ? {24'b0, exp_id_ff}
                                                          : {31'b0, id_chk_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         id_chk_ff <= 1'b0;
         exp_id_ff <= 8'h00;
      end else if (wr_en) begin
         if (paddr[2] == u2p_pkg::REG_ID_CHECK) id_chk_ff <= pwdata[0];
         else exp_id_ff <= pwdata[7:0];
      end
   end

   // input decode
   assign in_keys[0] = req_ch.key_slot0;
   assign in_keys[1] = req_ch.key_slot1;
   assign in_keys[2] = req_ch.key_slot2;
   assign in_keys[3] = req_ch.key_slot3;
   assign in_keys[4] = req_ch.key_slot4;
   assign in_keys[5] = req_ch.key_slot5;

   assign req_ch.ready = (state_ff == u2p_pkg::ST_IDLE);
   assign accept = req_ch.valid && req_ch.ready;
   assign idx8   = {1'b0, req_ch.map_index};
   assign map_wr = accept && req_ch.cmd && ({1'b0, idx8} < 9'(u2p_pkg::MAP_DEPTH));
   assign start  = accept && !req_ch.cmd
                   && !(id_chk_ff && (req_ch.report_id_byte != exp_id_ff));

   // event decode
   assign ev_is_mod = (ev_ff < u2p_pkg::EV_W'(u2p_pkg::MOD_COUNT));
   assign mod_idx   = ev_ff[2:0];
   assign mod_active = cur_mods_ff[mod_idx] ^ prev_mods_ff[mod_idx];
   assign ev_k      = ev_ff - u2p_pkg::EV_W'(u2p_pkg::MOD_COUNT);
   assign slot_raw  = ev_k[u2p_pkg::SLOT_W:1];
   assign slot_sel  = (int'(slot_raw) < u2p_pkg::KEY_SLOTS) ? slot_raw : '0;
   assign key_brk   = !ev_k[0];
   assign was       = prev_keys_ff[slot_sel];
   assign now       = cur_keys_ff[slot_sel];
   assign code      = key_brk ? was : now;
   assign key_active = (was != now) && (code != 8'h00) && (code < u2p_pkg::CODE_LIMIT)
                       && ({1'b0, code} < 9'(u2p_pkg::MAP_DEPTH));
   assign mem_rd    = (state_ff == u2p_pkg::ST_LOOK) && !ev_is_mod && key_active
                      && (ev_ff < u2p_pkg::EV_W'(u2p_pkg::EV_COUNT));

   // byte selection
   assign entry = use_mem_ff ? rd_q_ff : entry_ff;
   always_comb begin
      if ((ph_ff == u2p_pkg::PH_EXT) && entry[u2p_pkg::EXT_BIT]) begin
         sel      = u2p_pkg::PH_EXT;
         gen_byte = u2p_pkg::PFX_EXT;
      end else if ((ph_ff != u2p_pkg::PH_CODE) && brk_ff) begin
         sel      = u2p_pkg::PH_BREAK;
         gen_byte = u2p_pkg::PFX_BREAK;
      end else begin
         sel      = u2p_pkg::PH_CODE;
         gen_byte = entry[7:0];
      end
   end

   assign can_push = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in      = state_ff;
      ev_in         = ev_ff;
      ph_in         = ph_ff;
      brk_in        = brk_ff;
      use_mem_in    = use_mem_ff;
      entry_in      = entry_ff;
      pend_valid_in = pend_valid_ff;
      pend_byte_in  = pend_byte_ff;
      push          = 1'b0;
      out_last_in   = out_last_ff;
      out_byte_in   = out_byte_ff;
      case (state_ff)
         u2p_pkg::ST_IDLE: begin
            if (start) begin
               ev_in    = '0;
               state_in = u2p_pkg::ST_LOOK;
            end
         end
         u2p_pkg::ST_LOOK: begin
            ph_in = u2p_pkg::PH_EXT;
            if (ev_ff >= u2p_pkg::EV_W'(u2p_pkg::EV_COUNT)) begin
               state_in = u2p_pkg::ST_FLUSH;
            end else if (ev_is_mod) begin
               if (mod_active) begin
                  brk_in     = prev_mods_ff[mod_idx];
                  use_mem_in = 1'b0;
                  entry_in   = u2p_pkg::MOD_CODES[mod_idx];
                  state_in   = u2p_pkg::ST_BYTE;
               end else begin
                  ev_in = ev_ff + 1'b1;
               end
            end else if (key_active) begin
               brk_in     = key_brk;
               use_mem_in = 1'b1;
               state_in   = u2p_pkg::ST_BYTE;
            end else begin
               ev_in = ev_ff + 1'b1;
            end
         end
         u2p_pkg::ST_BYTE: begin
            if (!pend_valid_ff || can_push) begin
               push          = pend_valid_ff;
               if (pend_valid_ff) begin
                  out_byte_in = pend_byte_ff;
                  out_last_in = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_byte_in  = gen_byte;
               case (sel)
                  u2p_pkg::PH_EXT:   ph_in = u2p_pkg::PH_BREAK;
                  u2p_pkg::PH_BREAK: ph_in = u2p_pkg::PH_CODE;
                  default: begin
                     ph_in    = u2p_pkg::PH_EXT;
                     ev_in    = ev_ff + 1'b1;
                     state_in = u2p_pkg::ST_LOOK;
                  end
               endcase
            end
         end
         u2p_pkg::ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = u2p_pkg::ST_IDLE;
            end else if (can_push) begin
               push          = 1'b1;
               out_byte_in   = pend_byte_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = u2p_pkg::ST_IDLE;
            end
         end
         default: state_in = u2p_pkg::ST_IDLE;
      endcase
      out_valid_in = push ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= u2p_pkg::ST_IDLE;
         ev_ff         <= '0;
         ph_ff         <= u2p_pkg::PH_EXT;
         brk_ff        <= 1'b0;
         use_mem_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         prev_mods_ff  <= 8'h00;
         for (int s = 0; s < u2p_pkg::KEY_SLOTS; s++) prev_keys_ff[s] <= 8'h00;
      end else begin
         state_ff      <= state_in;
         ev_ff         <= ev_in;
         ph_ff         <= ph_in;
         brk_ff        <= brk_in;
         use_mem_ff    <= use_mem_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         if ((state_ff == u2p_pkg::ST_FLUSH) && (state_in == u2p_pkg::ST_IDLE)) begin
            prev_mods_ff <= cur_mods_ff;
            for (int s = 0; s < u2p_pkg::KEY_SLOTS; s++) prev_keys_ff[s] <= cur_keys_ff[s];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      entry_ff     <= entry_in;
      pend_byte_ff <= pend_byte_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      if (start) begin
         cur_mods_ff <= req_ch.modifier_bits;
         for (int s = 0; s < u2p_pkg::KEY_SLOTS; s++) cur_keys_ff[s] <= in_keys[s];
      end
   end

   // key map memory
   always_ff @(posedge clock) begin
      if (map_wr) key_map_mem[idx8[u2p_pkg::MAP_ADDR_W-1:0]] <= req_ch.map_entry;
      if (mem_rd) rd_q_ff <= key_map_mem[code[u2p_pkg::MAP_ADDR_W-1:0]];
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.scan_byte   = out_byte_ff;
   assign rsp_ch.parity_bit  = ~(^out_byte_ff);
   assign rsp_ch.last_of_run = out_last_ff;

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == u2p_pkg::ST_IDLE) |-> !pend_valid_ff)
      else $error("pending byte left while idle");

   a_ev_range: assert property (@(posedge clock) disable iff (reset)
      ev_ff <= u2p_pkg::EV_W'(u2p_pkg::EV_COUNT))
      else $error("event index out of range");

   a_flush_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == u2p_pkg::ST_FLUSH) && push) |=> (state_ff == u2p_pkg::ST_IDLE))
      else $error("flush did not end the run");

   a_last_from_flush: assert property (@(posedge clock) disable iff (reset)
      (push && out_last_in) |-> (state_ff == u2p_pkg::ST_FLUSH))
      else $error("last beat issued mid-run");

endmodule
